// ===== hdl/chp_pkg.sv =====
// Shared types and constants of the circle hit pick block.
// No dependencies; chp_front, chp_back and the top level import this package.
package chp_pkg;

  // Table capacity and derived widths
  localparam int MAX_OBJECTS = 256;
  localparam int IDX_W = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
  localparam int CNT_W = $clog2(MAX_OBJECTS + 1);

  // Operation codes of an input beat
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Command as classified by the front end
  typedef enum logic {
    CMD_LOAD,
    CMD_QUERY
  } cmd_t;

  // Back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DRAIN,
    BK_DONE
  } back_state_t;

  // Input beat
  typedef struct packed {
    logic               op;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [15:0]        radius;
    logic [15:0]        ref_id;
  } in_item_t;

  // Output beat
  typedef struct packed {
    logic        hit;
    logic [15:0] hit_ref;
  } out_item_t;

  // One stored object
  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [15:0]        radius;
    logic [15:0]        ref_id;
  } obj_t;

  // Queue entry between front and back end
  typedef struct packed {
    cmd_t cmd;
    obj_t obj;
  } q_entry_t;

endpackage

// ===== hdl/chp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
module chp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/chp_front.sv =====
// Front end: accepts input beats, drops loads beyond capacity, classifies
// the rest and holds them in a two-entry queue. Depends on chp_pkg.
module chp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  chp_pkg::in_item_t in_data,
  output logic              q_valid,
  input  logic              q_ready,
  output chp_pkg::q_entry_t q_data
);
  import chp_pkg::*;

  q_entry_t   entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic [CNT_W-1:0] load_cnt;

  logic     accept;
  logic     is_load;
  logic     drop;
  logic     push;
  logic     pop;
  q_entry_t entry_in;

  // Classify the incoming beat
  always_comb begin
    is_load = (in_data.op == OP_LOAD);
    drop    = is_load && (load_cnt == CNT_W'(MAX_OBJECTS));
    entry_in.cmd        = is_load ? CMD_LOAD : CMD_QUERY;
    entry_in.obj.pos_x  = in_data.pos_x;
    entry_in.obj.pos_y  = in_data.pos_y;
    entry_in.obj.pos_z  = in_data.pos_z;
    entry_in.obj.radius = in_data.radius;
    entry_in.obj.ref_id = in_data.ref_id;
  end

  assign in_ready = (fill != 2'd2);
  assign accept   = in_valid && in_ready;
  assign push     = accept && !drop;
  assign pop      = q_valid && q_ready;
  assign q_valid  = (fill != 2'd0);
  assign q_data   = entries[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= entry_in;
    end
  end

  // Queue pointers, fill level and accepted-load count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= 1'b0;
      rd_ptr   <= 1'b0;
      fill     <= 2'd0;
      load_cnt <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
      if (push && is_load) begin
        load_cnt <= load_cnt + CNT_W'(1);
      end
    end
  end

endmodule

// ===== hdl/chp_back.sv =====
// Back end: stores loads in the object RAM and runs the pick scan for
// queries through a hit-test pipeline. Depends on chp_pkg and chp_ram.
module chp_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_ready,
  input  chp_pkg::q_entry_t  q_data,
  output logic               out_valid,
  input  logic               out_ready,
  output chp_pkg::out_item_t out_data
);
  import chp_pkg::*;

  back_state_t state;
  back_state_t state_next;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] addr;
  logic signed [15:0] qx;
  logic signed [15:0] qy;

  // RAM ports
  logic             ram_we;
  logic             ram_re;
  obj_t             ram_rdata;
  logic [$bits(obj_t)-1:0] ram_rbits;

  // Pipeline stages
  logic        rd_v;
  logic        s1_v;
  logic [15:0] s1_mx;
  logic [15:0] s1_my;
  logic [15:0] s1_r;
  logic signed [15:0] s1_z;
  logic [15:0] s1_ref;
  logic        s2_v;
  logic [31:0] s2_sx;
  logic [31:0] s2_sy;
  logic [31:0] s2_sr;
  logic signed [15:0] s2_z;
  logic [15:0] s2_ref;
  logic        s3_v;
  logic        s3_cover;
  logic signed [15:0] s3_z;
  logic [15:0] s3_ref;

  // Running pick
  logic        found;
  logic signed [15:0] best_z;
  logic [15:0] best_ref;

  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic        start_query;
  logic        do_load;
  logic        last_addr;
  logic        pipe_empty;
  logic        out_free;

  assign q_ready     = (state == BK_IDLE);
  assign do_load     = q_valid && q_ready && (q_data.cmd == CMD_LOAD);
  assign start_query = q_valid && q_ready && (q_data.cmd == CMD_QUERY);
  assign last_addr   = ((addr + CNT_W'(1)) == count);
  assign pipe_empty  = !rd_v && !s1_v && !s2_v && !s3_v;
  assign out_free    = !out_valid || out_ready;
  assign ram_we      = do_load;
  assign ram_re      = (state == BK_SCAN);
  assign ram_rdata   = obj_t'(ram_rbits);

  chp_ram #(
    .WIDTH($bits(obj_t)),
    .DEPTH(MAX_OBJECTS)
  ) u_obj_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count[IDX_W-1:0]),
    .wdata(q_data.obj),
    .re   (ram_re),
    .raddr(addr[IDX_W-1:0]),
    .rdata(ram_rbits)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (start_query) begin
          state_next = (count == '0) ? BK_DRAIN : BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (last_addr) begin
          state_next = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        if (pipe_empty) begin
          state_next = BK_DONE;
        end
      end
      BK_DONE: begin
        if (out_free) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // Control registers: count, scan address, valid bits, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      addr      <= '0;
      rd_v      <= 1'b0;
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (do_load) begin
        count <= count + CNT_W'(1);
      end
      if (start_query) begin
        addr <= '0;
      end else if (state == BK_SCAN) begin
        addr <= addr + CNT_W'(1);
      end
      rd_v <= (state == BK_SCAN);
      s1_v <= rd_v;
      s2_v <= s1_v;
      s3_v <= s2_v;
      if (start_query) begin
        found <= 1'b0;
      end else if (s3_v && s3_cover && (!found || (s3_z > best_z))) begin
        found <= 1'b1;
      end
      if (state == BK_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Stage 1: absolute coordinate differences
  always_comb begin
    dx = 17'(qx) - 17'(ram_rdata.pos_x);
    dy = 17'(qy) - 17'(ram_rdata.pos_y);
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (start_query) begin
      qx <= q_data.obj.pos_x;
      qy <= q_data.obj.pos_y;
    end
    s1_mx  <= dx[16] ? 16'(-dx) : dx[15:0];
    s1_my  <= dy[16] ? 16'(-dy) : dy[15:0];
    s1_r   <= ram_rdata.radius;
    s1_z   <= ram_rdata.pos_z;
    s1_ref <= ram_rdata.ref_id;
    // Stage 2: squares
    s2_sx  <= s1_mx * s1_mx;
    s2_sy  <= s1_my * s1_my;
    s2_sr  <= s1_r * s1_r;
    s2_z   <= s1_z;
    s2_ref <= s1_ref;
    // Stage 3: disc test
    s3_cover <= ({1'b0, s2_sx} + {1'b0, s2_sy}) <= {1'b0, s2_sr};
    s3_z     <= s2_z;
    s3_ref   <= s2_ref;
    // Keep the topmost hit; earlier object wins on equal depth
    if (s3_v && s3_cover && (!found || (s3_z > best_z))) begin
      best_z   <= s3_z;
      best_ref <= s3_ref;
    end
    // Load the output register
    if (state == BK_DONE && out_free) begin
      out_data.hit     <= found;
      out_data.hit_ref <= found ? best_ref : 16'd0;
    end
  end

endmodule

// ===== hdl/circle_hit_pick_top_depth.sv =====
// Top level of the circle hit pick block: front end, queue and back end.
// Depends on chp_pkg, chp_front, chp_back (and chp_ram through chp_back).
//
// Load beats append an object (x, y, depth, radius, id) to a table of
// MAX_OBJECTS entries and return nothing; loads past a full table are
// dropped. A query beat returns one beat with the id of the covering
// object of greatest depth, earliest stored first on ties, or hit = 0.
// A load writes the object RAM and leaves the back end idle. A query
// is taken, then its scan reads one stored object per cycle from the
// object RAM, then the four-stage hit-test pipeline drains into the
// running pick, and then the result register is loaded; an empty table
// skips the scan. A result that the receiver stalls holds the next
// query at its result step until it is taken. A two-entry queue lets
// the input side keep accepting while the back end is busy.
// The table starts empty after reset; no clearing pass is needed.
module circle_hit_pick_top_depth (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  chp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output chp_pkg::out_item_t out_data
);
  import chp_pkg::*;

  logic     q_valid;
  logic     q_ready;
  q_entry_t q_data;

  chp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data (in_data),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_data  (q_data)
  );

  chp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_data   (q_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule
